/* rtl/sitda_pkg.sv */
package sitda_pkg;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam int         MaxDigits = 10;

	typedef struct packed {
		logic load;
		logic count;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic last_pos;
		logic out_valid;
	} sts_t;

	function automatic logic [31:0] pow10(input logic [3:0] p);
		logic [31:0] r;
		unique case (p)
			4'd0:    r = 32'd1;
			4'd1:    r = 32'd10;
			4'd2:    r = 32'd100;
			4'd3:    r = 32'd1000;
			4'd4:    r = 32'd10000;
			4'd5:    r = 32'd100000;
			4'd6:    r = 32'd1000000;
			4'd7:    r = 32'd10000000;
			4'd8:    r = 32'd100000000;
			4'd9:    r = 32'd1000000000;
			default: r = 32'd1;
		endcase
		return r;
	endfunction

endpackage

/* rtl/sitda_ctrl.sv */
module sitda_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	input  sitda_pkg::sts_t sts,
	output sitda_pkg::cmd_t cmd
);
	import sitda_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_SIGN  = 2'd2;
	localparam logic [1:0] ST_DIGIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       can_emit;

	assign can_emit = !sts.out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = sts.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (can_emit) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (can_emit) begin
					cmd.emit_digit = 1'b1;
					if (sts.last_pos) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/sitda_dp.sv */
module sitda_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  sitda_pkg::cmd_t cmd,
	output sitda_pkg::sts_t sts,
	input  logic [31:0]     value,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [7:0]      ascii_char,
	output logic [3:0]      text_length,
	output logic            last_char
);
	import sitda_pkg::*;

	logic [31:0] mag_q;
	logic        neg_q;
	logic [3:0]  pos_q;
	logic [3:0]  len_q;
	logic [7:0]  ascii_char_q;
	logic [3:0]  text_length_q;
	logic        last_char_q;
	logic        out_valid_q;

	logic [3:0]  ndig;
	logic [31:0] pow;
	logic [33:0] mult [1:9];
	logic [3:0]  digit;
	logic [33:0] sub;

	// digit count of the magnitude
	always_comb begin
		ndig = 4'd1;
		for (int i = 1; i < MaxDigits; i++) begin
			if (mag_q >= pow10(4'(i))) begin
				ndig = ndig + 4'd1;
			end
		end
	end

	// one decimal digit per step, most significant first
	assign pow = pow10(pos_q);

	always_comb begin
		digit = 4'd0;
		sub   = '0;
		for (int k = 1; k <= 9; k++) begin
			mult[k] = 34'(k) * {2'b00, pow};
			if ({2'b00, mag_q} >= mult[k]) begin
				digit = 4'(k);
				sub   = mult[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (~value + 32'd1) : value;
		end else if (cmd.emit_digit) begin
			mag_q <= mag_q - sub[31:0];
		end
		if (cmd.count) begin
			pos_q <= ndig - 4'd1;
			len_q <= ndig + {3'b000, neg_q};
		end else if (cmd.emit_digit) begin
			pos_q <= pos_q - 4'd1;
		end
		if (cmd.emit_sign) begin
			ascii_char_q  <= CharMinus;
			text_length_q <= len_q;
			last_char_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			ascii_char_q  <= CharZero + {4'b0000, digit};
			text_length_q <= len_q;
			last_char_q   <= (pos_q == 4'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.neg       = neg_q;
	assign sts.last_pos  = (pos_q == 4'd0);
	assign sts.out_valid = out_valid_q;

	assign out_valid   = out_valid_q;
	assign ascii_char  = ascii_char_q;
	assign text_length = text_length_q;
	assign last_char   = last_char_q;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// channel   signals                                          direction
// input     in_valid, in_ready, value[31:0]                  one integer per transaction
// output    out_valid, out_ready, ascii_char[7:0],           one character per transaction
//           text_length[3:0], last_char
//
// an integer gives 1 to 11 characters; no new integer is taken before its last character is emitted
// the digit loop does one compare-and-subtract against the multiples of a power
// of ten per cycle unless the output stalls, after a state that counts the digits
// arst_n clears the controller and the output valid; no other state
// a stalled output holds the character register and pauses the digit loop
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  ascii_char,
	output logic [3:0]  text_length,
	output logic        last_char
);
	import sitda_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sitda_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.ascii_char  (ascii_char),
		.text_length (text_length),
		.last_char   (last_char)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a conversion is in flight");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_length >= 4'd1 && text_length <= 4'd11)
		else $error("text length out of range");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_char == CharMinus) ||
			(ascii_char >= CharZero && ascii_char <= CharZero + 8'd9))
		else $error("character is neither sign nor digit");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ascii_char == CharMinus |-> !last_char)
		else $error("sign marked as last character");

endmodule
